// File: src/mkls_pkg.sv
package mkls_pkg;

  localparam int unsigned MAX_KEYWORDS  = 4;
  localparam int unsigned KEYWORD_BYTES = 8;
  localparam int unsigned LINE_LIMIT    = 98;
  localparam int unsigned WORD_REGS     = 4;

  localparam int unsigned NUM_KW     = (MAX_KEYWORDS < WORD_REGS) ? MAX_KEYWORDS : WORD_REGS;
  localparam int unsigned WINDOW_W   = 8 * KEYWORD_BYTES;
  localparam int unsigned RECENT_W   = 8 * (KEYWORD_BYTES - 1);
  localparam int unsigned FILL_W     = $clog2(LINE_LIMIT + 1);
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned LENGTHS_W  = 16;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic {
    FUNC_DATA = 1'b0,
    FUNC_EOF  = 1'b1
  } func_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SEARCH_MODE     = 3'd0,
    REG_PATTERN_COUNT   = 3'd1,
    REG_PATTERN_LENGTHS = 3'd2,
    REG_PATTERN_WORD_0  = 3'd3,
    REG_PATTERN_WORD_1  = 3'd4,
    REG_PATTERN_WORD_2  = 3'd5,
    REG_PATTERN_WORD_3  = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic                               search_mode;
    logic [COUNT_W-1:0]                 pattern_count;
    logic [LENGTHS_W-1:0]               pattern_lengths;
    logic [WORD_REGS-1:0][WORD_W-1:0]   pattern_words;
  } cfg_t;

  // Keyword length, saturated to the keyword buffer size.
  function automatic logic [LEN_W-1:0] keyword_len(input logic [LENGTHS_W-1:0] lengths,
                                                   input int unsigned k);
    logic [LEN_W-1:0] len;
    len = lengths[LEN_W*k +: LEN_W];
    if (len > LEN_W'(KEYWORD_BYTES)) begin
      len = LEN_W'(KEYWORD_BYTES);
    end
    return len;
  endfunction

  // One bit for each keyword in use; the count saturates to the keyword slots.
  function automatic logic [NUM_KW-1:0] active_mask(input logic [COUNT_W-1:0] count);
    logic [NUM_KW-1:0] mask;
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      mask[k] = (32'(count) > k);
    end
    return mask;
  endfunction

endpackage

// File: src/mkls_intf.sv
interface mkls_in_if;
  import mkls_pkg::*;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface mkls_out_if;
  logic valid;
  logic ready;
  logic file_matched;
  modport source (output valid, output file_matched, input ready);
  modport sink   (input valid, input file_matched, output ready);
endinterface

interface mkls_cfg_if;
  import mkls_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/mkls_cfg_regs.sv
module mkls_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  mkls_cfg_if.sink        cfg_i,
  output mkls_pkg::cfg_t  cfg_o
);
  import mkls_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_SEARCH_MODE:     cfg_q.search_mode     <= cfg_i.data[0];
        REG_PATTERN_COUNT:   cfg_q.pattern_count   <= cfg_i.data[COUNT_W-1:0];
        REG_PATTERN_LENGTHS: cfg_q.pattern_lengths <= cfg_i.data[LENGTHS_W-1:0];
        REG_PATTERN_WORD_0:  cfg_q.pattern_words[0] <= cfg_i.data[WORD_W-1:0];
        REG_PATTERN_WORD_1:  cfg_q.pattern_words[1] <= cfg_i.data[WORD_W-1:0];
        REG_PATTERN_WORD_2:  cfg_q.pattern_words[2] <= cfg_i.data[WORD_W-1:0];
        REG_PATTERN_WORD_3:  cfg_q.pattern_words[3] <= cfg_i.data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/mkls_matcher.sv
module mkls_matcher (
  input  mkls_pkg::cfg_t                        cfg_i,
  input  logic [mkls_pkg::WINDOW_W-1:0]         window_i,
  input  logic [mkls_pkg::FILL_W-1:0]           fill_i,
  output logic [mkls_pkg::NUM_KW-1:0]           byte_hits_o,
  output logic [mkls_pkg::NUM_KW-1:0]           empty_kw_o
);
  import mkls_pkg::*;

  logic [NUM_KW-1:0][KEYWORD_BYTES:1] match_by_len;
  logic [NUM_KW-1:0][LEN_W-1:0]       len;
  logic [NUM_KW-1:0]                  active;

  assign active = active_mask(cfg_i.pattern_count);

  // The newest byte sits in the low byte of the window, so the keyword's first
  // byte is compared against the oldest byte of a window of its own length.
  always_comb begin
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      len[k] = keyword_len(cfg_i.pattern_lengths, k);
      for (int unsigned l = 1; l <= KEYWORD_BYTES; l++) begin
        match_by_len[k][l] = 1'b1;
        for (int unsigned i = 0; i < KEYWORD_BYTES; i++) begin
          if (i < l) begin
            if (window_i[8*(l-1-i) +: 8] != cfg_i.pattern_words[k][8*i +: 8]) begin
              match_by_len[k][l] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      empty_kw_o[k]  = active[k] && (len[k] == '0);
      byte_hits_o[k] = empty_kw_o[k];
      for (int unsigned l = 1; l <= KEYWORD_BYTES; l++) begin
        if (active[k] && (len[k] == LEN_W'(l)) && (FILL_W'(l) <= fill_i)
            && match_by_len[k][l]) begin
          byte_hits_o[k] = 1'b1;
        end
      end
    end
  end

endmodule

// File: src/multi_keyword_line_search.sv
// Searches one file, sent as a stream of bytes and closed by an end-of-file
// item, for up to four keywords of up to eight bytes. One item is taken every
// clock cycle unless an end-of-file item waits for the output register. All
// keywords are compared combinationally against the newest bytes of the line
// between the input register and the search state, so the sustained rate is
// one byte per cycle. The file_matched result of an end-of-file item is loaded
// into the output register as the item leaves the input register. Data bytes
// keep flowing while a result waits in the output register, but a further
// end-of-file item waits until it leaves. Registers are to be written only
// while no file is in progress; there is no clearing pass after reset.
module multi_keyword_line_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  mkls_cfg_if.sink    cfg_i,
  mkls_in_if.sink     in_i,
  mkls_out_if.source  out_o
);
  import mkls_pkg::*;

  cfg_t cfg;

  // Input register.
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;

  // Search state.
  logic [RECENT_W-1:0] recent_q, recent_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [NUM_KW-1:0]   line_hits_q, line_hits_d;
  logic [NUM_KW-1:0]   found_q, found_d;
  logic                stopped_q, stopped_d;
  logic                match_q, match_d;

  // Result register.
  logic out_valid_q;
  logic out_matched_q;

  logic                out_free;
  logic                advance;
  logic [WINDOW_W-1:0] window;
  logic [FILL_W-1:0]   fill_next;
  logic [NUM_KW-1:0]   byte_hits;
  logic [NUM_KW-1:0]   empty_kw;
  logic [NUM_KW-1:0]   active;
  logic                finish;
  logic [NUM_KW-1:0]   finish_hits;
  logic [NUM_KW-1:0]   found_all;
  logic                line_hit;

  mkls_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign window    = {recent_q, in_byte_q};
  assign fill_next = fill_q + FILL_W'(1);
  assign active    = active_mask(cfg.pattern_count);

  mkls_matcher u_matcher (
    .cfg_i       (cfg),
    .window_i    (window),
    .fill_i      (fill_next),
    .byte_hits_o (byte_hits),
    .empty_kw_o  (empty_kw)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = in_valid_q && ((in_func_q == FUNC_DATA) || out_free);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.file_matched = out_matched_q;

  always_comb begin
    recent_d    = recent_q;
    fill_d      = fill_q;
    line_hits_d = line_hits_q;
    found_d     = found_q;
    stopped_d   = stopped_q;
    match_d     = match_q;
    finish      = 1'b0;
    finish_hits = line_hits_q;

    if (in_func_q == FUNC_EOF) begin
      recent_d    = '0;
      fill_d      = '0;
      line_hits_d = '0;
      found_d     = '0;
      stopped_d   = 1'b0;
      match_d     = 1'b0;
    end else if (!stopped_q) begin
      if (in_byte_q == NEWLINE_BYTE) begin
        if (fill_q == '0) begin
          stopped_d = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end else begin
        recent_d    = window[RECENT_W-1:0];
        fill_d      = fill_next;
        line_hits_d = line_hits_q | byte_hits;
        finish_hits = line_hits_d;
        // A line that reaches the limit is evaluated on its last byte.
        if (fill_next >= FILL_W'(LINE_LIMIT)) begin
          finish = 1'b1;
        end
      end
    end

    found_all = found_q | ((finish_hits | empty_kw) & active);
    if (cfg.search_mode) begin
      line_hit = |((finish_hits | empty_kw) & active);
    end else begin
      line_hit = ((found_all & active) == active);
    end

    if (finish) begin
      if (!cfg.search_mode) begin
        found_d = found_all;
      end
      if (line_hit) begin
        match_d   = 1'b1;
        stopped_d = 1'b1;
      end
      recent_d    = '0;
      fill_d      = '0;
      line_hits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q    <= '0;
      fill_q      <= '0;
      line_hits_q <= '0;
      found_q     <= '0;
      stopped_q   <= 1'b0;
      match_q     <= 1'b0;
    end else if (advance) begin
      recent_q    <= recent_d;
      fill_q      <= fill_d;
      line_hits_q <= line_hits_d;
      found_q     <= found_d;
      stopped_q   <= stopped_d;
      match_q     <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && (in_func_q == FUNC_EOF)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (in_func_q == FUNC_EOF)) begin
      out_matched_q <= match_q;
    end
  end

  // Once stopped, the line has been cleared and stays empty until end of file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (fill_q == '0))
    else $error("search stopped with a partial line");

  // A match always stops the search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> stopped_q)
    else $error("match recorded without stopping the search");

  // The line never holds the limit or more bytes between items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(LINE_LIMIT))
    else $error("line fill reached the limit");

  // An end-of-file item leaving the input register always produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_func_q == FUNC_EOF)) |=> out_valid_q)
    else $error("end of file gave no result");

endmodule
